### src/ksc_pkg.sv
// Shared types and constants for the scancode modifier event FIFO.
// Holds queue sizing, command and status codes, scancodes and bit masks.
// No dependencies.
package ksc_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH = 256;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int CODE_W  = 7;
  localparam int MODS_W  = 5;
  localparam int LED_W   = 3;
  localparam int EVENT_W = CODE_W + MODS_W + 1;

  // Commands
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_MOD   = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  // Control sequencer states
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_t;

  // Set-1 key codes (release bit removed)
  localparam logic [CODE_W-1:0] SC_LCTRL = 7'h1D;
  localparam logic [CODE_W-1:0] SC_SHIFT = 7'h2A;
  localparam logic [CODE_W-1:0] SC_ALT   = 7'h38;
  localparam logic [CODE_W-1:0] SC_CAPS  = 7'h3A;

  // Modifier masks
  localparam logic [MODS_W-1:0] MOD_NONE  = 5'h00;
  localparam logic [MODS_W-1:0] MOD_LCTRL = 5'h01;
  localparam logic [MODS_W-1:0] MOD_ALT   = 5'h04;
  localparam logic [MODS_W-1:0] MOD_SHIFT = 5'h08;
  localparam logic [MODS_W-1:0] MOD_CAPS  = 5'h10;

  // LED masks
  localparam logic [LED_W-1:0] LED_NUM  = 3'h2;
  localparam logic [LED_W-1:0] LED_CAPS = 3'h4;

  // Modifier unit to controller
  typedef struct packed {
    logic              is_mod;
    logic              is_caps;
    logic [MODS_W-1:0] mods;
    logic [LED_W-1:0]  led_next;
  } mod_info_t;

endpackage

### src/ksc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module ksc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/ksc_mod.sv
// Modifier and LED tracker: decodes modifier scancodes and holds modifier/LED bits.
// Depends on ksc_pkg.
module ksc_mod
  import ksc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       apply,
  input  logic [7:0] scancode,
  output mod_info_t  info
);

  logic [MODS_W-1:0] mods_r, mods_nxt;
  logic [LED_W-1:0]  led_r, led_nxt;
  logic [CODE_W-1:0] code;
  logic              released;
  logic [MODS_W-1:0] bit_sel;

  assign code     = scancode[CODE_W-1:0];
  assign released = scancode[7];

  // Decode the modifier key
  always_comb begin
    unique case (code)
      SC_LCTRL: bit_sel = MOD_LCTRL;
      SC_SHIFT: bit_sel = MOD_SHIFT;
      SC_ALT:   bit_sel = MOD_ALT;
      SC_CAPS:  bit_sel = MOD_CAPS;
      default:  bit_sel = MOD_NONE;
    endcase
  end

  // Set on press, clear on release
  always_comb begin
    mods_nxt = released ? (mods_r & ~bit_sel) : (mods_r | bit_sel);
    led_nxt  = led_r;
    if (code == SC_CAPS) begin
      led_nxt = released ? (led_r & ~LED_CAPS) : (led_r | LED_CAPS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= MOD_NONE;
      led_r  <= LED_NUM;
    end else if (apply && (bit_sel != MOD_NONE)) begin
      mods_r <= mods_nxt;
      led_r  <= led_nxt;
    end
  end

  assign info.is_mod   = (bit_sel != MOD_NONE);
  assign info.is_caps  = (code == SC_CAPS);
  assign info.mods     = mods_r;
  assign info.led_next = led_nxt;

`ifndef NO_ASSERTIONS
  // Caps LED follows the caps modifier once any caps code is applied
  a_caps_led_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (apply && info.is_caps) |=> (led_r[2] == mods_r[4]))
    else $error("caps LED and caps modifier diverged");

  // Non-modifier codes leave the tracker untouched
  a_hold_non_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (!(apply && info.is_mod)) |=> ($stable(mods_r) && $stable(led_r)))
    else $error("modifier state changed without a modifier code");

  // Right ctrl bit is never set
  a_no_rctrl: assert property (@(posedge clk) disable iff (!rst_n)
    mods_r[1] == 1'b0)
    else $error("right ctrl modifier bit set");
`endif

endmodule

### src/scancode_modifier_event_fifo.sv
// Top level: set-1 scancode modifier tracker with an event queue in RAM.
// Depends on ksc_pkg, ksc_ram and ksc_mod.
//
// Channel  | Direction | Ports                                        | Handshake
// ---------+-----------+----------------------------------------------+--------------
// in       | input     | in_cmd, in_scancode                          | in_valid/in_stall
// out      | output    | out_status, out_event_*, out_led_*           | out_valid/out_stall
//
// A scancode's result is in the output register after the accepting edge. A
// read passes through the READ state, since the RAM read data is registered;
// no new item is accepted until the read result is loaded.
// A scancode waits in the input while the output register holds an untaken
// result; a read is accepted and its RAM access issued regardless.
// Reset clears indices, fill count, modifiers and LEDs (num lock on); the
// queue RAM is not cleared and needs no clearing pass.
module scancode_modifier_event_fifo
  import ksc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_scancode,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [CODE_W-1:0] out_event_code,
  output logic [MODS_W-1:0] out_event_modifiers,
  output logic              out_event_released,
  output logic              out_led_write,
  output logic [LED_W-1:0]  out_led_value
);

  fsm_t              state_r, state_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              empty_rd_r, empty_rd_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [MODS_W-1:0] emods_r, emods_nxt;
  logic              rel_r, rel_nxt;
  logic              ledw_r, ledw_nxt;
  logic [LED_W-1:0]  ledv_r, ledv_nxt;

  logic              out_free;
  logic              scan_xfer;
  logic              read_xfer;
  logic              full;
  logic              ram_we;
  logic              ram_re;
  logic [EVENT_W-1:0] ram_wdata;
  logic [EVENT_W-1:0] ram_rdata;
  mod_info_t         minfo;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != FSM_IDLE) || ((in_cmd == CMD_SCAN) && !out_free);
  assign scan_xfer = in_valid && !in_stall && (in_cmd == CMD_SCAN);
  assign read_xfer = in_valid && !in_stall && (in_cmd == CMD_READ);
  assign full      = (fill_r == CNT_W'(QUEUE_DEPTH));

  // Modifier tracker
  ksc_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .apply    (scan_xfer),
    .scancode (in_scancode),
    .info     (minfo)
  );

  // Event queue storage: {released, modifiers, code}
  assign ram_wdata = {in_scancode[7], minfo.mods, in_scancode[CODE_W-1:0]};

  ksc_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_idx_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rdata)
  );

  // Sequencer, queue pointers and result loading
  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    fill_nxt      = fill_r;
    empty_rd_nxt  = empty_rd_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    code_nxt      = code_r;
    emods_nxt     = emods_r;
    rel_nxt       = rel_r;
    ledw_nxt      = ledw_r;
    ledv_nxt      = ledv_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    unique case (state_r)
      FSM_IDLE: begin
        if (scan_xfer) begin
          out_valid_nxt = 1'b1;
          code_nxt      = '0;
          emods_nxt     = '0;
          rel_nxt       = 1'b0;
          ledw_nxt      = 1'b0;
          ledv_nxt      = '0;
          if (minfo.is_mod) begin
            status_nxt = STS_MOD;
            if (minfo.is_caps) begin
              ledw_nxt = 1'b1;
              ledv_nxt = minfo.led_next;
            end
          end else if (full) begin
            status_nxt = STS_FULL;
          end else begin
            // Push the event
            status_nxt = STS_OK;
            ram_we     = 1'b1;
            wr_idx_nxt = (wr_idx_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
            fill_nxt   = fill_r + 1'b1;
          end
        end else if (read_xfer) begin
          state_nxt    = FSM_READ;
          empty_rd_nxt = (fill_r == '0);
          if (fill_r != '0) begin
            // Issue the RAM read and pop now
            ram_re     = 1'b1;
            rd_idx_nxt = (rd_idx_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_r + 1'b1;
            fill_nxt   = fill_r - 1'b1;
          end
        end
      end
      FSM_READ: begin
        // Load the read result once the output register frees
        if (out_free) begin
          state_nxt     = FSM_IDLE;
          out_valid_nxt = 1'b1;
          ledw_nxt      = 1'b0;
          ledv_nxt      = '0;
          if (empty_rd_r) begin
            status_nxt = STS_EMPTY;
            code_nxt   = '0;
            emods_nxt  = '0;
            rel_nxt    = 1'b0;
          end else begin
            status_nxt = STS_OK;
            code_nxt   = ram_rdata[CODE_W-1:0];
            emods_nxt  = ram_rdata[CODE_W +: MODS_W];
            rel_nxt    = ram_rdata[EVENT_W-1];
          end
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      fill_r      <= '0;
      empty_rd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      fill_r      <= fill_nxt;
      empty_rd_r  <= empty_rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    code_r   <= code_nxt;
    emods_r  <= emods_nxt;
    rel_r    <= rel_nxt;
    ledw_r   <= ledw_nxt;
    ledv_r   <= ledv_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_event_code      = code_r;
  assign out_event_modifiers = emods_r;
  assign out_event_released  = rel_r;
  assign out_led_write       = ledw_r;
  assign out_led_value       = ledv_r;

`ifndef NO_ASSERTIONS
  // Fill count never exceeds the queue depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // An empty queue has matching pointers
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (wr_idx_r == rd_idx_r))
    else $error("pointers differ on an empty queue");

  // Read state is entered only from an accepted read
  a_read_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == FSM_READ) |-> $past(read_xfer))
    else $error("read state entered without a read transfer");

  // A waiting read result is never lost under output stall
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_READ && !out_free) |=> (state_r == FSM_READ))
    else $error("read result dropped while output stalled");
`endif

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for scancode_modifier_event_fifo: directed and random
// scancode/read traffic, checked against an in-bench model of the event queue.
// Depends on ksc_pkg and the scancode_modifier_event_fifo RTL.
module tb_top;
  import ksc_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          END_CYCLES  = 10;
  localparam int          HOLD_CYCLES = 400;
  localparam int          HOLD_AT     = 120;
  localparam logic [7:0]  REL_BIT     = 8'h80;

  typedef struct {
    logic       cmd;
    logic [7:0] scancode;
  } key_item_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [MODS_W-1:0] mods;
    logic              rel;
  } key_event_t;

  typedef struct {
    status_t           status;
    logic [CODE_W-1:0] code;
    logic [MODS_W-1:0] mods;
    logic              rel;
    logic              led_wr;
    logic [LED_W-1:0]  led_val;
  } key_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_SCAN;
  logic [7:0]        in_scancode = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [CODE_W-1:0] out_event_code;
  logic [MODS_W-1:0] out_event_modifiers;
  logic              out_event_released;
  logic              out_led_write;
  logic [LED_W-1:0]  out_led_value;

  // Model state: queue contents, pointers, modifiers and LEDs
  key_event_t        ev_ram [QUEUE_DEPTH];
  logic [IDX_W-1:0]  wr_ptr = '0;
  logic [IDX_W-1:0]  rd_ptr = '0;
  int unsigned       fill_level = 0;
  logic [MODS_W-1:0] mod_state = MOD_NONE;
  logic [LED_W-1:0]  led_state = LED_NUM;

  key_item_t   key_items[$];
  key_result_t pending_results[$];
  int unsigned total_items = 0;
  int unsigned taken = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  scancode_modifier_event_fifo u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_scancode         (in_scancode),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_event_code      (out_event_code),
    .out_event_modifiers (out_event_modifiers),
    .out_event_released  (out_event_released),
    .out_led_write       (out_led_write),
    .out_led_value       (out_led_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle phase: sender light / receiver heavy, then swapped, then no idling
  function automatic int idle_phase();
    if (taken < total_items / 3) return 0;
    if (taken < 2 * total_items / 3) return 1;
    return 2;
  endfunction

  function automatic logic sender_idles();
    int pct;
    pct = (idle_phase() == 0) ? 30 : (idle_phase() == 1) ? 72 : 0;
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic receiver_idles();
    int pct;
    pct = (idle_phase() == 0) ? 72 : (idle_phase() == 1) ? 30 : 0;
    return $urandom_range(99) < pct;
  endfunction

  // Advance the model by one accepted transfer and queue its result
  task automatic track_key_item(input logic cmd, input logic [7:0] sc);
    key_result_t       res;
    logic [CODE_W-1:0] code;
    logic              rel;
    logic [MODS_W-1:0] mbit;
    res = '{STS_OK, '0, '0, 1'b0, 1'b0, '0};
    code = sc[CODE_W-1:0];
    rel = sc[7];
    if (cmd == CMD_READ) begin
      if (fill_level == 0) begin
        res.status = STS_EMPTY;
      end else begin
        res.code = ev_ram[rd_ptr].code;
        res.mods = ev_ram[rd_ptr].mods;
        res.rel  = ev_ram[rd_ptr].rel;
        rd_ptr = (rd_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        fill_level--;
      end
    end else if (code == SC_LCTRL || code == SC_SHIFT || code == SC_ALT || code == SC_CAPS) begin
      case (code)
        SC_LCTRL: mbit = MOD_LCTRL;
        SC_SHIFT: mbit = MOD_SHIFT;
        SC_ALT:   mbit = MOD_ALT;
        default:  mbit = MOD_CAPS;
      endcase
      mod_state = rel ? (mod_state & ~mbit) : (mod_state | mbit);
      res.status = STS_MOD;
      if (code == SC_CAPS) begin
        led_state = rel ? (led_state & ~LED_CAPS) : (led_state | LED_CAPS);
        res.led_wr  = 1'b1;
        res.led_val = led_state;
      end
    end else if (fill_level >= QUEUE_DEPTH) begin
      res.status = STS_FULL;
    end else begin
      ev_ram[wr_ptr] = '{code, mod_state, rel};
      wr_ptr = (wr_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      fill_level++;
    end
    pending_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result();
    key_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, status", out_status, 0);
      return;
    end
    want = pending_results.pop_front();
    if (out_status != want.status) report_mismatch("status", out_status, want.status);
    if (out_event_code != want.code) report_mismatch("event_code", out_event_code, want.code);
    if (out_event_modifiers != want.mods)
      report_mismatch("event_modifiers", out_event_modifiers, want.mods);
    if (out_event_released != want.rel)
      report_mismatch("event_released", out_event_released, want.rel);
    if (out_led_write != want.led_wr) report_mismatch("led_write", out_led_write, want.led_wr);
    if (out_led_value != want.led_val) report_mismatch("led_value", out_led_value, want.led_val);
  endtask

  task automatic add_item(input logic cmd, input logic [7:0] sc);
    key_items.push_back('{cmd, sc});
    total_items++;
  endtask

  // Random modifier byte, press or release
  function automatic logic [7:0] modifier_byte();
    logic [CODE_W-1:0] code;
    case ($urandom_range(3))
      0:       code = SC_LCTRL;
      1:       code = SC_SHIFT;
      2:       code = SC_ALT;
      default: code = SC_CAPS;
    endcase
    return {1'($urandom_range(1)), code};
  endfunction

  // Key byte for a push burst: mostly plain keys, some modifier changes
  function automatic logic [7:0] key_byte();
    if ($urandom_range(99) < 12) return modifier_byte();
    return 8'($urandom_range(255));
  endfunction

  // Drive the input channel; hold the payload while stalled
  always @(posedge clk) begin
    key_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_key_item(in_cmd, in_scancode);
        taken++;
      end
      if (!in_valid || !in_stall) begin
        if (key_items.size() != 0 && !sender_idles()) begin
          it = key_items.pop_front();
          in_valid    <= 1'b1;
          in_cmd      <= it.cmd;
          in_scancode <= it.scancode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (!hold_done && taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each result transfer and drive the stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= (hold_left != 0) || receiver_idles();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[scancode_modifier_event_fifo] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    // Directed: empty read, byte extremes, every modifier press and release,
    // repeated caps, prefix byte, then drain past empty
    add_item(CMD_READ, 8'hFF);
    add_item(CMD_SCAN, 8'h00);
    add_item(CMD_SCAN, 8'hFF);
    add_item(CMD_SCAN, {1'b0, SC_LCTRL});
    add_item(CMD_SCAN, {1'b0, SC_SHIFT});
    add_item(CMD_SCAN, {1'b0, SC_ALT});
    add_item(CMD_SCAN, {1'b0, SC_CAPS});
    add_item(CMD_SCAN, {1'b0, SC_CAPS});
    add_item(CMD_SCAN, 8'hE0);
    add_item(CMD_SCAN, 8'h90);
    add_item(CMD_SCAN, REL_BIT | {1'b0, SC_LCTRL});
    add_item(CMD_SCAN, REL_BIT | {1'b0, SC_SHIFT});
    add_item(CMD_SCAN, REL_BIT | {1'b0, SC_ALT});
    add_item(CMD_SCAN, REL_BIT | {1'b0, SC_CAPS});
    add_item(CMD_SCAN, REL_BIT | {1'b0, SC_CAPS});
    add_item(CMD_SCAN, 8'h7F);
    for (int i = 0; i < 6; i++) add_item(CMD_READ, 8'($urandom_range(255)));

    // Long push burst toward full, then drain past empty
    n = QUEUE_DEPTH + $urandom_range(10, 40);
    for (int i = 0; i < n; i++) add_item(CMD_SCAN, key_byte());
    n = QUEUE_DEPTH + $urandom_range(5, 30);
    for (int i = 0; i < n; i++) add_item(CMD_READ, 8'($urandom_range(255)));

    // Random bursts until about 1700 items
    while (total_items < 1700) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          n = $urandom_range(1, 40);
          for (int i = 0; i < n; i++) add_item(CMD_SCAN, key_byte());
        end
        3, 4, 5: begin
          n = $urandom_range(1, 40);
          for (int i = 0; i < n; i++) add_item(CMD_READ, 8'($urandom_range(255)));
        end
        6, 7: begin
          n = $urandom_range(1, 30);
          for (int i = 0; i < n; i++)
            add_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        8: begin
          add_item(CMD_SCAN, modifier_byte() & ~REL_BIT);
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) add_item(CMD_SCAN, 8'($urandom_range(255)));
          add_item(CMD_SCAN, modifier_byte() | REL_BIT);
        end
        default: begin
          n = QUEUE_DEPTH + $urandom_range(1, 24);
          for (int i = 0; i < n; i++) add_item(CMD_SCAN, key_byte());
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transfer and result, then let the pipe settle
    while (taken != total_items || pending_results.size() != 0) @(negedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[scancode_modifier_event_fifo] OK");
    end else begin
      $display("[scancode_modifier_event_fifo] ERROR");
    end
    $finish;
  end

endmodule
